// File: src/bcd_pkg.sv
package bcd_pkg;

  // Field and storage widths
  localparam int ID_W        = 11;
  localparam int BYTE_W      = 8;
  localparam int FRAME_BYTES = 8;
  localparam int QTY_W       = 4;
  localparam int VALUE_W     = 21;
  localparam int GEN_W       = 2;
  localparam int VOLT_W      = 10;
  localparam int RES_MAX     = 4;
  localparam int RES_IDX_W   = 2;
  localparam int RES_CNT_W   = 3;
  localparam int DIV_N_W     = 21;
  localparam int DIV_D_W     = 10;

  // Frame identifiers
  localparam logic [ID_W-1:0] ID_PACK_STATUS = 11'h1DB;
  localparam logic [ID_W-1:0] ID_PACK_LIMITS = 11'h1DC;
  localparam logic [ID_W-1:0] ID_PACK_SOC    = 11'h55B;
  localparam logic [ID_W-1:0] ID_TEMP_FIRST  = 11'h5BC;
  localparam logic [ID_W-1:0] ID_TEMP_SECOND = 11'h5C0;
  localparam logic [ID_W-1:0] ID_GEN_SECOND  = 11'h59E;
  localparam logic [ID_W-1:0] ID_GEN_THIRD_A = 11'h1C2;
  localparam logic [ID_W-1:0] ID_GEN_THIRD_B = 11'h1ED;

  // Arithmetic constants
  localparam logic [BYTE_W-1:0]  CRC_POLY    = 8'h85;
  localparam logic [VALUE_W-1:0] VALUE_MAX   = 21'd1046529;
  localparam int                 CUR_POS_MAX = 1023;
  localparam int                 CUR_WRAP    = 2047;
  localparam int                 PRE_MIN     = 400;
  localparam int                 PRE_OFFSET  = 40;
  localparam int                 LPV_LIMIT   = 900;
  localparam int                 TEMP_OFFSET = 40;
  localparam int                 AMPS_SCALE  = 2000;

  typedef enum logic [QTY_W-1:0] {
    Q_CRC_ERR   = 4'd0,
    Q_CURRENT   = 4'd1,
    Q_VOLTAGE   = 4'd2,
    Q_PRECHARGE = 4'd3,
    Q_POWER     = 4'd4,
    Q_CHG_AMPS  = 4'd5,
    Q_CHG_KW    = 4'd6,
    Q_DIS_KW    = 4'd7,
    Q_SOC       = 4'd8,
    Q_ISO       = 4'd9,
    Q_TEMP      = 4'd10
  } quantity_e;

  typedef enum logic [GEN_W-1:0] {
    GEN_FIRST  = 2'd0,
    GEN_SECOND = 2'd1,
    GEN_THIRD  = 2'd2
  } gen_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_DIV,
    ST_BUILD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef struct packed {
    quantity_e                  qty;
    logic signed [VALUE_W-1:0]  value;
  } result_t;

endpackage

// File: src/bcd_frame_if.sv
interface bcd_frame_if;
  logic                          valid;
  logic                          ready;
  logic [bcd_pkg::ID_W-1:0]      can_id;
  logic [bcd_pkg::BYTE_W-1:0]    data_byte_0;
  logic [bcd_pkg::BYTE_W-1:0]    data_byte_1;
  logic [bcd_pkg::BYTE_W-1:0]    data_byte_2;
  logic [bcd_pkg::BYTE_W-1:0]    data_byte_3;
  logic [bcd_pkg::BYTE_W-1:0]    data_byte_4;
  logic [bcd_pkg::BYTE_W-1:0]    data_byte_5;
  logic [bcd_pkg::BYTE_W-1:0]    data_byte_6;
  logic [bcd_pkg::BYTE_W-1:0]    data_byte_7;

  modport source (
    output valid, can_id, data_byte_0, data_byte_1, data_byte_2, data_byte_3,
           data_byte_4, data_byte_5, data_byte_6, data_byte_7,
    input  ready
  );

  modport sink (
    input  valid, can_id, data_byte_0, data_byte_1, data_byte_2, data_byte_3,
           data_byte_4, data_byte_5, data_byte_6, data_byte_7,
    output ready
  );
endinterface

// File: src/bcd_result_if.sv
interface bcd_result_if;
  logic                               valid;
  logic                               ready;
  logic [bcd_pkg::QTY_W-1:0]          quantity;
  logic signed [bcd_pkg::VALUE_W-1:0] value;
  logic                               last;

  modport source (
    output valid, quantity, value, last,
    input  ready
  );

  modport sink (
    input  valid, quantity, value, last,
    output ready
  );
endinterface

// File: src/bcd_crc_unit.sv
module bcd_crc_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bcd_pkg::BYTE_W-1:0] data_i [bcd_pkg::FRAME_BYTES],
  output logic [bcd_pkg::BYTE_W-1:0] crc_o,
  output bcd_pkg::unit_sts_t         sts_o
);
  import bcd_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES);

  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [BYTE_W-1:0] crc_q, crc_d;
  logic [BYTE_W-1:0] feed;
  logic              last_step;

  // Shift one byte through the CRC, MSB first
  function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] din);
    logic [BYTE_W-1:0] c;
    logic              top;
    c = crc;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      top = c[BYTE_W-1];
      c   = {c[BYTE_W-2:0], din[i]};
      if (top) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // The final step feeds a zero byte in place of the check byte
  assign last_step = (cnt_q == CNT_W'(FRAME_BYTES - 1));
  assign feed      = last_step ? '0 : data_i[cnt_q];
  assign crc_d     = crc_byte(crc_q, feed);

  // Advance one byte per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      crc_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      crc_q  <= '0;
    end else if (busy_q) begin
      crc_q <= crc_d;
      cnt_q <= cnt_q + 1'b1;
      if (last_step) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign crc_o      = crc_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// File: src/bcd_div_unit.sv
module bcd_div_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bcd_pkg::DIV_N_W-1:0] dividend_i,
  input  logic [bcd_pkg::DIV_D_W-1:0] divisor_i,
  output logic [bcd_pkg::DIV_N_W-1:0] quotient_o,
  output bcd_pkg::unit_sts_t          sts_o
);
  import bcd_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);

  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DIV_N_W-1:0] quo_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [DIV_D_W-1:0] dsr_q;
  logic [DIV_D_W:0]   partial;
  logic [DIV_D_W:0]   diff;
  logic               fits;
  logic               last_step;

  // Restoring step: bring down one dividend bit, subtract if it fits
  assign partial   = {rem_q, quo_q[DIV_N_W-1]};
  assign fits      = (partial >= {1'b0, dsr_q});
  assign diff      = partial - {1'b0, dsr_q};
  assign last_step = (cnt_q == CNT_W'(DIV_N_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last_step) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Hold the datapath; load on start, shift while busy
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_N_W-2:0], fits};
      rem_q <= fits ? diff[DIV_D_W-1:0] : partial[DIV_D_W-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// File: src/bms_can_frame_decoder.sv
// Battery-pack CAN frame decoder.
// frame_i takes one CAN frame (11-bit identifier, eight payload bytes) per
// request; result_o gives zero to four results per frame, each a quantity
// code and a signed 21-bit fixed-point value, with last set on the final one.
// cfg_we_i/cfg_wdata_i write the shunt-present bit; write it while idle.
// One frame is worked on at a time; frame_i.ready is high only when idle.
// On the way from request to first result a frame passes these states:
//   identifiers not checked    build, then emit, or idle if no result
//   checked, no division       CRC (byte-serial unit, 8 steps), build, emit
//   limits frame, division     CRC, bit-serial divider (21 steps), build, emit
// A checked frame with no result goes from build back to idle. Each further
// result of the same frame is given once the one before it has been taken.
// A stalled result holds on result_o until taken; the next frame is taken
// once the last result of the current one has gone.
// Reset clears the shunt bit, the pack generation (first) and the last pack
// voltage (zero) and returns to idle.
module bms_can_frame_decoder (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  bcd_frame_if.sink    frame_i,
  bcd_result_if.source result_o
);
  import bcd_pkg::*;

  state_e state_q, state_d;

  logic [ID_W-1:0]      id_q;
  logic [BYTE_W-1:0]    byte_q [FRAME_BYTES];
  gen_e                 gen_q;
  logic [VOLT_W-1:0]    lpv_q;
  logic                 shunt_q;
  result_t              res_q [RES_MAX];
  logic [RES_CNT_W-1:0] cnt_q;
  logic [RES_IDX_W-1:0] idx_q;

  logic [BYTE_W-1:0]    crc_val;
  unit_sts_t            crc_sts;
  unit_sts_t            div_sts;
  logic [DIV_N_W-1:0]   quotient;
  logic [DIV_N_W-1:0]   dividend;
  logic                 crc_start;
  logic                 div_start;
  logic                 frame_acc;
  logic                 result_acc;
  logic                 emit_last;
  logic                 in_checked;
  logic                 id_checked;
  logic                 crc_ok;
  logic                 need_div;

  result_t              build_res [RES_MAX];
  logic [RES_CNT_W-1:0] build_cnt;

  // Decoded fields
  logic [10:0]          cur_raw;
  logic signed [11:0]   cur_s;
  logic [VOLT_W-1:0]    udc;
  logic signed [22:0]   power_full;
  logic [7:0]           chg_kw;
  logic [9:0]           lim;
  logic [VALUE_W-1:0]   amps;

  function automatic logic is_checked(input logic [ID_W-1:0] id);
    return (id == ID_PACK_STATUS) || (id == ID_PACK_LIMITS) || (id == ID_PACK_SOC);
  endfunction

  assign frame_acc  = frame_i.valid && frame_i.ready;
  assign result_acc = result_o.valid && result_o.ready;
  assign in_checked = is_checked(frame_i.can_id);
  assign id_checked = is_checked(id_q);
  assign crc_ok     = (crc_val == byte_q[FRAME_BYTES-1]);
  assign need_div   = crc_ok && (id_q == ID_PACK_LIMITS) && (lpv_q != '0);
  assign emit_last  = ((RES_CNT_W'(idx_q) + 1'b1) == cnt_q);

  // Shared serial units
  bcd_crc_unit u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crc_start),
    .data_i  (byte_q),
    .crc_o   (crc_val),
    .sts_o   (crc_sts)
  );

  assign lim      = {byte_q[2][3:0], byte_q[3][7:2]};
  assign dividend = DIV_N_W'(lim) * DIV_N_W'(AMPS_SCALE);

  bcd_div_unit u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (lpv_q),
    .quotient_o (quotient),
    .sts_o      (div_sts)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (frame_i.valid) begin
          state_d = in_checked ? ST_CRC : ST_BUILD;
        end
      end
      ST_CRC: begin
        if (crc_sts.done) begin
          state_d = need_div ? ST_DIV : ST_BUILD;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_d = ST_BUILD;
        end
      end
      ST_BUILD: begin
        state_d = (build_cnt == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (result_o.ready && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    frame_i.ready   = (state_q == ST_IDLE);
    result_o.valid  = (state_q == ST_EMIT);
    crc_start       = frame_acc && in_checked;
    div_start       = (state_q == ST_CRC) && crc_sts.done && need_div;
    result_o.quantity = res_q[idx_q].qty;
    result_o.value    = res_q[idx_q].value;
    result_o.last     = emit_last;
  end

  // Field extraction and arithmetic
  assign cur_raw    = {byte_q[0], byte_q[1][7:5]};
  assign cur_s      = (cur_raw > 11'(CUR_POS_MAX)) ?
                      ($signed({1'b0, cur_raw}) - 12'sd2047) : $signed({1'b0, cur_raw});
  assign udc        = {byte_q[2], byte_q[3][7:6]};
  assign power_full = $signed({1'b0, udc}) * cur_s;
  assign chg_kw     = {byte_q[1][5:0], byte_q[2][7:6]};
  assign amps       = ((lpv_q == '0) || (quotient >= VALUE_MAX)) ? VALUE_MAX : quotient;

  // Build the result list of the frame
  always_comb begin
    for (int i = 0; i < RES_MAX; i++) begin
      build_res[i].qty   = Q_CRC_ERR;
      build_res[i].value = '0;
    end
    build_cnt = '0;
    if (id_checked && !crc_ok) begin
      build_cnt = RES_CNT_W'(1);
    end else begin
      unique case (id_q)
        ID_PACK_STATUS: begin
          if (!shunt_q) begin
            build_res[0].qty   = Q_CURRENT;
            build_res[0].value = VALUE_W'(cur_s);
            build_res[1].qty   = Q_VOLTAGE;
            build_res[1].value = VALUE_W'(udc);
            if (udc > VOLT_W'(PRE_MIN)) begin
              build_res[2].qty   = Q_PRECHARGE;
              build_res[2].value = VALUE_W'(udc) - VALUE_W'(PRE_OFFSET);
              build_res[3].qty   = Q_POWER;
              build_res[3].value = power_full[VALUE_W-1:0];
              build_cnt          = RES_CNT_W'(4);
            end else begin
              build_res[2].qty   = Q_POWER;
              build_res[2].value = power_full[VALUE_W-1:0];
              build_cnt          = RES_CNT_W'(3);
            end
          end
        end
        ID_PACK_LIMITS: begin
          build_res[0].qty   = Q_CHG_AMPS;
          build_res[0].value = amps;
          build_res[1].qty   = Q_CHG_KW;
          build_res[1].value = VALUE_W'(chg_kw);
          build_res[2].qty   = Q_DIS_KW;
          build_res[2].value = VALUE_W'(byte_q[0]);
          build_cnt          = RES_CNT_W'(3);
        end
        ID_PACK_SOC: begin
          if (!shunt_q) begin
            build_res[0].qty   = Q_SOC;
            build_res[0].value = VALUE_W'({byte_q[0], byte_q[1][7:6]});
            build_res[1].qty   = Q_ISO;
            build_res[1].value = VALUE_W'({byte_q[4], byte_q[5][7:6]});
            build_cnt          = RES_CNT_W'(2);
          end else begin
            build_res[0].qty   = Q_ISO;
            build_res[0].value = VALUE_W'({byte_q[4], byte_q[5][7:6]});
            build_cnt          = RES_CNT_W'(1);
          end
        end
        ID_TEMP_FIRST: begin
          if (gen_q == GEN_FIRST) begin
            build_res[0].qty   = Q_TEMP;
            build_res[0].value = VALUE_W'(byte_q[3]) - VALUE_W'(TEMP_OFFSET);
            build_cnt          = RES_CNT_W'(1);
          end
        end
        ID_TEMP_SECOND: begin
          if ((gen_q == GEN_SECOND) && (byte_q[0][7:6] == 2'b01)) begin
            build_res[0].qty   = Q_TEMP;
            build_res[0].value = VALUE_W'(byte_q[2][7:1]) - VALUE_W'(TEMP_OFFSET);
            build_cnt          = RES_CNT_W'(1);
          end
        end
        default: build_cnt = '0;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gen_q   <= GEN_FIRST;
      lpv_q   <= '0;
      shunt_q <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        shunt_q <= cfg_wdata_i;
      end
      // Update pack state on a good frame
      if (state_q == ST_BUILD) begin
        cnt_q <= build_cnt;
        idx_q <= '0;
        if ((id_q == ID_PACK_STATUS) && crc_ok && !shunt_q && (udc < VOLT_W'(LPV_LIMIT))) begin
          lpv_q <= udc;
        end
        if (id_q == ID_GEN_SECOND) begin
          if (gen_q != GEN_THIRD) begin
            gen_q <= GEN_SECOND;
          end
        end else if ((id_q == ID_GEN_THIRD_A) || (id_q == ID_GEN_THIRD_B)) begin
          gen_q <= GEN_THIRD;
        end
      end else if (result_acc && !emit_last) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Frame and result payload
  always_ff @(posedge clk_i) begin
    if (frame_acc) begin
      id_q      <= frame_i.can_id;
      byte_q[0] <= frame_i.data_byte_0;
      byte_q[1] <= frame_i.data_byte_1;
      byte_q[2] <= frame_i.data_byte_2;
      byte_q[3] <= frame_i.data_byte_3;
      byte_q[4] <= frame_i.data_byte_4;
      byte_q[5] <= frame_i.data_byte_5;
      byte_q[6] <= frame_i.data_byte_6;
      byte_q[7] <= frame_i.data_byte_7;
    end
    if (state_q == ST_BUILD) begin
      res_q <= build_res;
    end
  end

`ifndef SYNTHESIS
  a_crc_in_crc_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_sts.busy |-> (state_q == ST_CRC))
    else $error("crc unit busy outside crc state");

  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.busy |-> (state_q == ST_DIV))
    else $error("divider busy outside divide state");

  a_emit_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (RES_CNT_W'(idx_q) < cnt_q))
    else $error("result index beyond result count");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_acc && result_o.last) |=> frame_i.ready)
    else $error("not ready after last result of a frame");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bcd_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int DRAIN_CYCLES   = 50;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [ID_W-1:0]                    can_id;
    logic [FRAME_BYTES-1:0][BYTE_W-1:0] data;
  } frame_t;

  typedef struct {
    quantity_e          qty;
    logic [VALUE_W-1:0] value;
    logic               last;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  bcd_frame_if  frame_bus ();
  bcd_result_if result_bus ();

  bms_can_frame_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_bus),
    .result_o    (result_bus)
  );

  // Decoder state as predicted by the testbench
  logic          shunt_model;
  gen_e          gen_model;
  logic [VOLT_W-1:0] pack_volts_model;

  frame_result_t expected_results[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            calm = 1'b0;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Pick a gap length: mostly short, sometimes long
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // CRC-8, poly 0x85, over bytes 0..6 followed by one zero byte
  function automatic logic [BYTE_W-1:0] crc_of(frame_t f);
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] cur_byte;
    logic              top;
    crc = '0;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      cur_byte = (k == FRAME_BYTES - 1) ? '0 : f.data[k];
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        top = crc[BYTE_W-1];
        crc = {crc[BYTE_W-2:0], cur_byte[i]};
        if (top) crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic bit is_checked(logic [ID_W-1:0] id);
    return id == ID_PACK_STATUS || id == ID_PACK_LIMITS || id == ID_PACK_SOC;
  endfunction

  function automatic frame_t seal(frame_t f);
    f.data[FRAME_BYTES-1] = crc_of(f);
    return f;
  endfunction

  function automatic frame_t corrupt(frame_t f);
    f.data[FRAME_BYTES-1] = crc_of(f) ^ BYTE_W'($urandom_range(1, 255));
    return f;
  endfunction

  function automatic frame_t frame_of(logic [ID_W-1:0] id);
    frame_t f;
    f.can_id = id;
    for (int k = 0; k < FRAME_BYTES; k++) f.data[k] = BYTE_W'($urandom);
    return f;
  endfunction

  function automatic frame_t filled_frame(logic [ID_W-1:0] id, logic [BYTE_W-1:0] fill);
    frame_t f;
    f.can_id = id;
    for (int k = 0; k < FRAME_BYTES; k++) f.data[k] = fill;
    return seal(f);
  endfunction

  function automatic frame_t status_frame(logic [10:0] cur, logic [VOLT_W-1:0] udc);
    frame_t f;
    f = frame_of(ID_PACK_STATUS);
    f.data[0]      = cur[10:3];
    f.data[1][7:5] = cur[2:0];
    f.data[2]      = udc[9:2];
    f.data[3][7:6] = udc[1:0];
    return seal(f);
  endfunction

  function automatic frame_t temp_second_frame(logic [1:0] tag, logic [BYTE_W-1:0] raw);
    frame_t f;
    f = frame_of(ID_TEMP_SECOND);
    f.data[0][7:6] = tag;
    f.data[2]      = raw;
    return f;
  endfunction

  // Work out the results one accepted frame causes and advance the state
  task automatic predict_frame(input frame_t f);
    quantity_e     qs[RES_MAX];
    int            vs[RES_MAX];
    int            n;
    int            cur, udc, dis, chg, lim, amps, q;
    frame_result_t r;
    n = 0;
    if (is_checked(f.can_id) && crc_of(f) != f.data[FRAME_BYTES-1]) begin
      qs[0] = Q_CRC_ERR;
      vs[0] = 0;
      n     = 1;
    end else begin
      case (f.can_id)
        ID_PACK_STATUS: begin
          if (!shunt_model) begin
            cur = int'({f.data[0], f.data[1][7:5]});
            udc = int'({f.data[2], f.data[3][7:6]});
            if (cur > CUR_POS_MAX) cur = cur - CUR_WRAP;
            qs[n] = Q_CURRENT; vs[n] = cur; n++;
            qs[n] = Q_VOLTAGE; vs[n] = udc; n++;
            if (udc < LPV_LIMIT) pack_volts_model = VOLT_W'(udc);
            if (udc > PRE_MIN) begin
              qs[n] = Q_PRECHARGE; vs[n] = udc - PRE_OFFSET; n++;
            end
            qs[n] = Q_POWER; vs[n] = udc * cur; n++;
          end
        end
        ID_PACK_LIMITS: begin
          dis  = int'({f.data[0], f.data[1][7:6]}) >> 2;
          chg  = int'({f.data[1][5:0], f.data[2][7:4]}) >> 2;
          lim  = int'({f.data[2][3:0], f.data[3][7:2]});
          amps = int'(VALUE_MAX);
          if (pack_volts_model != 0) begin
            q = lim * AMPS_SCALE / int'(pack_volts_model);
            if (q < int'(VALUE_MAX)) amps = q;
          end
          qs[n] = Q_CHG_AMPS; vs[n] = amps; n++;
          qs[n] = Q_CHG_KW;   vs[n] = chg;  n++;
          qs[n] = Q_DIS_KW;   vs[n] = dis;  n++;
        end
        ID_PACK_SOC: begin
          if (!shunt_model) begin
            qs[n] = Q_SOC; vs[n] = int'({f.data[0], f.data[1][7:6]}); n++;
          end
          qs[n] = Q_ISO; vs[n] = int'({f.data[4], f.data[5][7:6]}); n++;
        end
        ID_TEMP_FIRST: begin
          if (gen_model == GEN_FIRST) begin
            qs[n] = Q_TEMP; vs[n] = int'(f.data[3]) - TEMP_OFFSET; n++;
          end
        end
        ID_TEMP_SECOND: begin
          if (gen_model == GEN_SECOND && f.data[0][7:6] == 2'b01) begin
            qs[n] = Q_TEMP; vs[n] = int'(f.data[2] >> 1) - TEMP_OFFSET; n++;
          end
        end
        ID_GEN_SECOND: begin
          if (gen_model != GEN_THIRD) gen_model = GEN_SECOND;
        end
        ID_GEN_THIRD_A, ID_GEN_THIRD_B: gen_model = GEN_THIRD;
        default: ;
      endcase
    end
    for (int i = 0; i < n; i++) begin
      r.qty   = qs[i];
      r.value = VALUE_W'(vs[i]);
      r.last  = (i == n - 1);
      expected_results.push_back(r);
    end
  endtask

  // Offer one frame, with an optional idle gap first, and hold until taken
  task automatic send_frame(input frame_t f);
    int gap;
    @(negedge clk_i);
    gap = (!calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      frame_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    frame_bus.valid       <= 1'b1;
    frame_bus.can_id      <= f.can_id;
    frame_bus.data_byte_0 <= f.data[0];
    frame_bus.data_byte_1 <= f.data[1];
    frame_bus.data_byte_2 <= f.data[2];
    frame_bus.data_byte_3 <= f.data[3];
    frame_bus.data_byte_4 <= f.data[4];
    frame_bus.data_byte_5 <= f.data[5];
    frame_bus.data_byte_6 <= f.data[6];
    frame_bus.data_byte_7 <= f.data[7];
    do @(posedge clk_i); while (!frame_bus.ready);
    predict_frame(f);
  endtask

  // Drop the request, drain, let the block settle, then write the shunt bit
  task automatic write_shunt(input logic shunt);
    @(negedge clk_i);
    frame_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= shunt;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    shunt_model = shunt;
  endtask

  // Saturation of charger amps: zero pack voltage, then a tiny one
  task automatic test_charger_saturation();
    send_frame(filled_frame(ID_PACK_LIMITS, 8'hFF));
    send_frame(status_frame(11'd0, 10'd1));
    send_frame(filled_frame(ID_PACK_LIMITS, 8'hFF));
    send_frame(filled_frame(ID_PACK_LIMITS, 8'h00));
  endtask

  // Current wrap, precharge threshold and pack-voltage hold limits
  task automatic test_status_fields();
    send_frame(status_frame(11'd1023, 10'd1023));
    send_frame(status_frame(11'd1024, 10'd401));
    send_frame(status_frame(11'd2047, 10'd900));
    send_frame(status_frame(11'd0, 10'd400));
    send_frame(status_frame(11'd3, 10'd899));
  endtask

  task automatic test_crc_errors();
    send_frame(corrupt(frame_of(ID_PACK_STATUS)));
    send_frame(corrupt(frame_of(ID_PACK_LIMITS)));
    send_frame(corrupt(frame_of(ID_PACK_SOC)));
  endtask

  task automatic test_soc_iso();
    send_frame(filled_frame(ID_PACK_SOC, 8'hFF));
    send_frame(filled_frame(ID_PACK_SOC, 8'h00));
  endtask

  task automatic test_first_gen_temp();
    send_frame(filled_frame(ID_TEMP_FIRST, 8'h00));
    send_frame(filled_frame(ID_TEMP_FIRST, 8'hFF));
  endtask

  // With a shunt fitted only isolation and the limits frame report
  task automatic test_shunt_fitted();
    write_shunt(1'b1);
    send_frame(status_frame(11'd700, 10'd500));
    send_frame(seal(frame_of(ID_PACK_SOC)));
    send_frame(seal(frame_of(ID_PACK_LIMITS)));
    write_shunt(1'b0);
  endtask

  task automatic test_second_gen();
    send_frame(frame_of(ID_GEN_SECOND));
    send_frame(temp_second_frame(2'b01, 8'h00));
    send_frame(temp_second_frame(2'b01, 8'hFF));
    send_frame(temp_second_frame(2'b11, 8'h80));
    send_frame(frame_of(ID_TEMP_FIRST));
  endtask

  // Third generation sticks; unknown identifiers stay silent
  task automatic test_third_gen();
    send_frame(frame_of(ID_GEN_THIRD_A));
    send_frame(frame_of(ID_GEN_SECOND));
    send_frame(temp_second_frame(2'b01, 8'h55));
    send_frame(frame_of(ID_TEMP_FIRST));
    send_frame(frame_of(ID_GEN_THIRD_B));
    send_frame(frame_of(11'h000));
    send_frame(frame_of(11'h7FF));
  endtask

  // Random frame, biased to decoded identifiers with a valid CRC;
  // generation changes are kept at or below gen_ceiling
  function automatic frame_t random_frame(int gen_ceiling);
    frame_t f;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      f = frame_of(ID_PACK_STATUS);
    else if (pick < 50) f = frame_of(ID_PACK_LIMITS);
    else if (pick < 65) f = frame_of(ID_PACK_SOC);
    else if (pick < 75) f = frame_of(ID_TEMP_FIRST);
    else if (pick < 85) begin
      f = frame_of(ID_TEMP_SECOND);
      if ($urandom_range(0, 1) == 0) f.data[0][7:6] = 2'b01;
    end else if (pick < 90) begin
      case (gen_ceiling)
        0:       f = frame_of(ID_TEMP_FIRST);
        1:       f = frame_of(ID_GEN_SECOND);
        default: f = frame_of($urandom_range(0, 1) ? ID_GEN_THIRD_A : ID_GEN_THIRD_B);
      endcase
    end else begin
      f = frame_of(ID_W'($urandom_range(0, 2047)));
      if ((f.can_id == ID_GEN_SECOND && gen_ceiling < 1) ||
          ((f.can_id == ID_GEN_THIRD_A || f.can_id == ID_GEN_THIRD_B) && gen_ceiling < 2))
        f.can_id = 11'h7FF;
    end
    if (is_checked(f.can_id)) begin
      if ($urandom_range(0, 9) == 0) f = corrupt(f);
      else f = seal(f);
    end
    return f;
  endfunction

  task automatic run_random(input int count, input int gen_ceiling);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send_frame(random_frame(gen_ceiling));
    end
    calm = 1'b0;
  endtask

  // Result-side ready: random stalls unless in a calm stretch
  initial begin
    int stall_left;
    stall_left = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_bus.ready <= 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (expected_results.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: qty %0d value %0d last %0d",
                   result_bus.quantity, result_bus.value, result_bus.last);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (result_bus.quantity !== want.qty || result_bus.value !== want.value ||
            result_bus.last !== want.last) begin
          if (mismatches < REPORT_LIMIT)
            $display("mismatch: want qty %0d value %0d last %0d, got qty %0d value %0d last %0d",
                     want.qty, $signed(want.value), want.last,
                     result_bus.quantity, result_bus.value, result_bus.last);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no request taken on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((frame_bus.valid && frame_bus.ready) || (result_bus.valid && result_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = 1'b0;
    frame_bus.valid       = 1'b0;
    frame_bus.can_id      = '0;
    frame_bus.data_byte_0 = '0;
    frame_bus.data_byte_1 = '0;
    frame_bus.data_byte_2 = '0;
    frame_bus.data_byte_3 = '0;
    frame_bus.data_byte_4 = '0;
    frame_bus.data_byte_5 = '0;
    frame_bus.data_byte_6 = '0;
    frame_bus.data_byte_7 = '0;
    shunt_model           = 1'b0;
    gen_model             = GEN_FIRST;
    pack_volts_model      = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_shunt(1'b0);
    test_charger_saturation();
    test_status_fields();
    test_crc_errors();
    test_soc_iso();
    test_first_gen_temp();
    test_shunt_fitted();
    run_random(160, 0);
    test_second_gen();
    write_shunt(1'b1);
    run_random(160, 1);
    write_shunt(1'b0);
    test_third_gen();
    run_random(80, 2);
    write_shunt(1'b1);
    run_random(80, 2);
    write_shunt(1'b0);

    // Drain and let the block go quiet
    @(negedge clk_i);
    frame_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
